@@ rtl/core/mfr_pkg.sv @@
// Shared types, constants and CRC helper for the motor feedback frame receiver
`default_nettype none
package mfr_pkg;

    // frame layout
    localparam int unsigned FRAME_BYTES = 16;
    localparam int unsigned CRC_BYTES   = FRAME_BYTES - 2;

    // header bytes
    localparam logic [7:0] HEAD_0 = 8'hFD;
    localparam logic [7:0] HEAD_1 = 8'hEE;

    // CRC-16/XModem: poly 0x1021, init 0, msb first, no reflection, no final xor
    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_TOP  = 16'h8000;
    localparam logic [15:0] CRC_INIT = 16'h0000;

    // field masks
    localparam logic [7:0] ID_MASK    = 8'h0F;
    localparam logic [7:0] ERR_MASK   = 8'h07;
    localparam logic [7:0] FORCE_MASK = 8'hF0;

    // motor count register after reset
    localparam logic [4:0] MOTOR_COUNT_RESET = 5'd2;

    // frame check codes
    typedef enum logic [1:0] {
        RC_OK           = 2'd0,
        RC_BAD_HEADER   = 2'd1,
        RC_CRC_MISMATCH = 2'd2,
        RC_BAD_ID       = 2'd3
    } t_result_code;

    // one decoded frame
    typedef struct packed {
        t_result_code       result_code;
        logic [3:0]         unit_id;
        logic [2:0]         mode_status;
        logic signed [15:0] torque_raw;
        logic signed [15:0] speed_raw;
        logic signed [31:0] position_raw;
        logic [7:0]         temperature;
        logic [2:0]         motor_error;
        logic [11:0]        load_raw;
    } t_frame_result;

    // one byte of CRC update, unrolled over eight bit steps
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if ((c & CRC_TOP) != 16'h0000) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage
`default_nettype wire

@@ rtl/core/mfr_frame_core.sv @@
// Byte counter, running CRC, frame byte store and field decode
`default_nettype none
module mfr_frame_core (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_advance,
    input  wire logic [7:0]            i_byte,
    input  wire logic                  i_start,
    input  wire logic [4:0]            i_motor_count,
    output logic                       o_last,
    output mfr_pkg::t_frame_result     o_result
);

    logic [4:0]  r_count;
    logic [15:0] r_crc;
    logic [7:0]  r_store [0:mfr_pkg::FRAME_BYTES-1];

    logic [4:0]  w_count;
    logic [15:0] w_crc;
    logic        w_active;
    logic [15:0] n_crc;
    logic [15:0] w_rx_crc;
    logic [3:0]  w_id;

    // start flag restarts count and crc for this byte
    assign w_count  = i_start ? 5'd0 : r_count;
    assign w_crc    = i_start ? mfr_pkg::CRC_INIT : r_crc;
    assign w_active = (w_count < 5'(mfr_pkg::FRAME_BYTES));
    assign o_last   = (w_count == 5'(mfr_pkg::FRAME_BYTES - 1));

    // crc covers bytes 0 through 13, header included
    always_comb begin
        if (w_count < 5'(mfr_pkg::CRC_BYTES)) begin
            n_crc = mfr_pkg::crc_byte(w_crc, i_byte);
        end else begin
            n_crc = w_crc;
        end
    end

    // count and crc state, count holds once the frame is complete
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 5'd0;
            r_crc   <= mfr_pkg::CRC_INIT;
        end else if (i_advance && w_active) begin
            r_count <= w_count + 5'd1;
            r_crc   <= n_crc;
        end
    end

    // frame byte store
    always_ff @(posedge i_clk) begin
        if (i_advance && w_active) begin
            r_store[w_count[3:0]] <= i_byte;
        end
    end

    // last byte is the crc low byte, taken straight from the input
    assign w_rx_crc = {r_store[14], i_byte};
    assign w_id     = 4'(r_store[2] & mfr_pkg::ID_MASK);

    // check order: header, crc, motor id
    always_comb begin
        if (r_store[0] != mfr_pkg::HEAD_0 || r_store[1] != mfr_pkg::HEAD_1) begin
            o_result.result_code = mfr_pkg::RC_BAD_HEADER;
        end else if (w_rx_crc != r_crc) begin
            o_result.result_code = mfr_pkg::RC_CRC_MISMATCH;
        end else if ({1'b0, w_id} >= i_motor_count) begin
            o_result.result_code = mfr_pkg::RC_BAD_ID;
        end else begin
            o_result.result_code = mfr_pkg::RC_OK;
        end
        o_result.unit_id      = w_id;
        o_result.mode_status  = r_store[2][6:4];
        o_result.torque_raw   = {r_store[5], r_store[4]};
        o_result.speed_raw    = {r_store[7], r_store[6]};
        o_result.position_raw = {r_store[11], r_store[10], r_store[9], r_store[8]};
        o_result.temperature  = r_store[12];
        o_result.motor_error  = 3'(r_store[13] & mfr_pkg::ERR_MASK);
        o_result.load_raw     = {4'((r_store[13] & mfr_pkg::FORCE_MASK) >> 4), r_store[14]};
    end

endmodule
`default_nettype wire

@@ rtl/core/motor_feedback_frame_receiver.sv @@
// Motor feedback frame receiver: byte input, CRC-16/XModem check, decoded result output
//
// Input channel: one frame byte per request (i_rx_byte, i_frame_start) on i_in_valid /
// o_in_ready. i_frame_start marks byte 0 and drops any partial frame. A frame is 16
// bytes: FD EE header, payload through byte 13, CRC big-endian in bytes 14 and 15.
// Output channel: one request per completed frame on o_out_valid / i_out_ready,
// carrying the check code and the raw decoded fields. Bytes after byte 15 are
// ignored until the next start flag.
// Configuration: i_cfg_we writes i_cfg_data to the motor count register at once.
// Path: the last byte passes the input register, then the result register; a waiting
// result can hold it in the input register. Throughput: one byte per cycle while no
// last byte is held. The CRC byte update and the store write use the input register.
// Reset: count and CRC clear, motor count returns to 2, both channels go empty.
// Stall: while a result waits, bytes that give no result still flow; only a frame's
// last byte holds in the input register, and o_in_ready drops behind it.
`default_nettype none
module motor_feedback_frame_receiver (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // configuration
    input  wire logic               i_cfg_we,
    input  wire logic [4:0]         i_cfg_data,
    // byte input
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic [7:0]         i_rx_byte,
    input  wire logic               i_frame_start,
    // frame result
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic [1:0]              o_result_code,
    output logic [3:0]              o_unit_id,
    output logic [2:0]              o_mode_status,
    output logic signed [15:0]      o_torque_raw,
    output logic signed [15:0]      o_speed_raw,
    output logic signed [31:0]      o_position_raw,
    output logic [7:0]              o_temperature,
    output logic [2:0]              o_motor_error,
    output logic [11:0]             o_load_raw
);

    logic [4:0]              r_motor_count;
    logic                    r_in_valid;
    logic [7:0]              r_in_byte;
    logic                    r_in_start;
    logic                    r_out_valid;
    mfr_pkg::t_frame_result  r_out;

    logic                    w_last;
    logic                    w_fire;
    logic                    w_stall;
    logic                    w_advance;
    mfr_pkg::t_frame_result  w_result;

    // motor count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_motor_count <= mfr_pkg::MOTOR_COUNT_RESET;
        end else if (i_cfg_we) begin
            r_motor_count <= i_cfg_data;
        end
    end

    // only a result-giving byte needs a free result register
    assign w_fire     = r_in_valid && w_last;
    assign w_stall    = w_fire && r_out_valid && !i_out_ready;
    assign w_advance  = r_in_valid && !w_stall;
    assign o_in_ready = !r_in_valid || !w_stall;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_byte  <= i_rx_byte;
            r_in_start <= i_frame_start;
        end
    end

    mfr_frame_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_advance     (w_advance),
        .i_byte        (r_in_byte),
        .i_start       (r_in_start),
        .i_motor_count (r_motor_count),
        .o_last        (w_last),
        .o_result      (w_result)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire && w_advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && w_advance) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_result_code  = r_out.result_code;
    assign o_unit_id      = r_out.unit_id;
    assign o_mode_status  = r_out.mode_status;
    assign o_torque_raw   = r_out.torque_raw;
    assign o_speed_raw    = r_out.speed_raw;
    assign o_position_raw = r_out.position_raw;
    assign o_temperature  = r_out.temperature;
    assign o_motor_error  = r_out.motor_error;
    assign o_load_raw     = r_out.load_raw;

`ifndef NO_ASSERTIONS
    // a held last byte stays in the input register
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stall |=> r_in_valid)
        else $error("stalled last byte lost from input register");

    // a new result only follows a frame's last byte
    a_rise_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_out_valid ##1 r_out_valid) |-> $past(w_fire))
        else $error("result raised without a completed frame");

    // a waiting result is not overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> $stable(r_out))
        else $error("waiting result overwritten");
`endif

endmodule
`default_nettype wire

@@ test/mfr_checker.sv @@
// Frame checker: follows the byte stream, predicts each frame result and compares it
`timescale 1ns / 1ps
module mfr_checker (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // configuration port as seen by the block
    input  wire logic               i_cfg_we,
    input  wire logic [4:0]         i_cfg_data,
    // byte channel
    input  wire logic               i_in_valid,
    input  wire logic               i_in_ready,
    input  wire logic [7:0]         i_rx_byte,
    input  wire logic               i_frame_start,
    // result channel
    input  wire logic               i_out_valid,
    input  wire logic               i_out_ready,
    input  wire logic [1:0]         i_result_code,
    input  wire logic [3:0]         i_unit_id,
    input  wire logic [2:0]         i_mode_status,
    input  wire logic signed [15:0] i_torque_raw,
    input  wire logic signed [15:0] i_speed_raw,
    input  wire logic signed [31:0] i_position_raw,
    input  wire logic [7:0]         i_temperature,
    input  wire logic [2:0]         i_motor_error,
    input  wire logic [11:0]        i_load_raw,
    // status for the top
    output int                      o_mismatches,
    output int                      o_pending,
    output int                      o_results,
    output logic [3:0]              o_codes_seen
);

    // shadow of the receiver state
    logic [4:0]             byte_pos;
    logic [15:0]            crc_run;
    logic [7:0]             frame_bytes [mfr_pkg::FRAME_BYTES];
    logic [4:0]             id_limit;
    mfr_pkg::t_frame_result expected_frames [$];

    // crc-16/xmodem, one data bit per step, msb first
    function automatic logic [15:0] xmodem_update(input logic [15:0] crc, input logic [7:0] d);
        logic [15:0] r;
        logic        fb;
        r = crc;
        for (int i = 7; i >= 0; i--) begin
            fb = r[15] ^ d[i];
            r  = {r[14:0], 1'b0};
            if (fb) begin
                r = r ^ mfr_pkg::CRC_POLY;
            end
        end
        return r;
    endfunction

    // one accepted byte: store it, fold it into the crc, decode on the last byte
    task automatic take_byte(input logic [7:0] b, input logic start);
        mfr_pkg::t_frame_result res;
        if (start) begin
            byte_pos = 5'd0;
            crc_run  = mfr_pkg::CRC_INIT;
        end
        if (byte_pos < mfr_pkg::FRAME_BYTES) begin
            frame_bytes[byte_pos[3:0]] = b;
            if (byte_pos < mfr_pkg::CRC_BYTES) begin
                crc_run = xmodem_update(crc_run, b);
            end
            byte_pos = byte_pos + 5'd1;
            if (byte_pos == mfr_pkg::FRAME_BYTES) begin
                // header first, then crc, then the motor id range
                if (frame_bytes[0] != mfr_pkg::HEAD_0 || frame_bytes[1] != mfr_pkg::HEAD_1) begin
                    res.result_code = mfr_pkg::RC_BAD_HEADER;
                end else if ({frame_bytes[14], frame_bytes[15]} != crc_run) begin
                    res.result_code = mfr_pkg::RC_CRC_MISMATCH;
                end else if ({1'b0, frame_bytes[2][3:0]} >= id_limit) begin
                    res.result_code = mfr_pkg::RC_BAD_ID;
                end else begin
                    res.result_code = mfr_pkg::RC_OK;
                end
                // raw fields are decoded whatever the code
                res.unit_id      = frame_bytes[2][3:0];
                res.mode_status  = frame_bytes[2][6:4];
                res.torque_raw   = {frame_bytes[5], frame_bytes[4]};
                res.speed_raw    = {frame_bytes[7], frame_bytes[6]};
                res.position_raw = {frame_bytes[11], frame_bytes[10],
                                    frame_bytes[9], frame_bytes[8]};
                res.temperature  = frame_bytes[12];
                res.motor_error  = frame_bytes[13][2:0];
                res.load_raw     = {frame_bytes[13][7:4], frame_bytes[14]};
                expected_frames.push_back(res);
            end
        end
    endtask

    // count a field mismatch, report only the first few
    task automatic compare_field(input string fld, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want) begin
            o_mismatches++;
            if (o_mismatches <= 10) begin
                $display("frame %0d %s: expected %0h, got %0h", o_results, fld, want, got);
            end
        end
    endtask

    // one result request against the oldest predicted frame
    task automatic check_result();
        mfr_pkg::t_frame_result want;
        if (expected_frames.size() == 0) begin
            o_mismatches++;
            if (o_mismatches <= 10) begin
                $display("result request with no frame pending, code %0d", i_result_code);
            end
            return;
        end
        want = expected_frames.pop_front();
        o_codes_seen[want.result_code] = 1'b1;
        compare_field("result_code", want.result_code, i_result_code);
        compare_field("unit_id", want.unit_id, i_unit_id);
        compare_field("mode_status", want.mode_status, i_mode_status);
        compare_field("torque_raw", want.torque_raw, i_torque_raw);
        compare_field("speed_raw", want.speed_raw, i_speed_raw);
        compare_field("position_raw", want.position_raw, i_position_raw);
        compare_field("temperature", want.temperature, i_temperature);
        compare_field("motor_error", want.motor_error, i_motor_error);
        compare_field("load_raw", want.load_raw, i_load_raw);
        o_results++;
    endtask

    // sample both channels at the clock edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            byte_pos     = 5'd0;
            crc_run      = mfr_pkg::CRC_INIT;
            id_limit     = mfr_pkg::MOTOR_COUNT_RESET;
            o_mismatches = 0;
            o_results    = 0;
            o_codes_seen = 4'b0000;
            expected_frames.delete();
        end else begin
            if (i_cfg_we) begin
                id_limit = i_cfg_data;
            end
            if (i_out_valid && i_out_ready) begin
                check_result();
            end
            if (i_in_valid && i_in_ready) begin
                take_byte(i_rx_byte, i_frame_start);
            end
        end
        o_pending = expected_frames.size();
    end

endmodule

@@ test/tb.sv @@
// Top of the frame receiver testbench: clock, reset, byte and result traffic, verdict
`timescale 1ns / 1ps
module tb;

    localparam int unsigned LONG_HOLD    = 80;
    localparam int unsigned DRAIN_CYCLES = 4;

    // kinds of generated frames
    typedef enum logic [1:0] {
        FK_GOOD,
        FK_BAD_HEAD,
        FK_BAD_CRC
    } t_frame_kind;

    // result side ready patterns
    typedef enum logic [1:0] {
        RX_OPEN,
        RX_MOSTLY,
        RX_SPARSE,
        RX_PERIODIC
    } t_rx_mode;

    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               i_cfg_we      = 1'b0;
    logic [4:0]         i_cfg_data    = 5'd0;
    logic               i_in_valid    = 1'b0;
    logic               o_in_ready;
    logic [7:0]         i_rx_byte     = 8'h00;
    logic               i_frame_start = 1'b0;
    logic               o_out_valid;
    logic               i_out_ready   = 1'b0;
    logic [1:0]         o_result_code;
    logic [3:0]         o_unit_id;
    logic [2:0]         o_mode_status;
    logic signed [15:0] o_torque_raw;
    logic signed [15:0] o_speed_raw;
    logic signed [31:0] o_position_raw;
    logic [7:0]         o_temperature;
    logic [2:0]         o_motor_error;
    logic [11:0]        o_load_raw;

    int          mismatches;
    int          pending;
    int          results;
    logic [3:0]  codes_seen;

    int unsigned bytes_sent       = 0;
    int unsigned settings_written = 0;
    int unsigned burst_left       = 0;
    bit          gaps_on          = 1'b1;
    bit          hold_wanted      = 1'b0;
    bit          hold_served      = 1'b0;

    motor_feedback_frame_receiver DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_rx_byte      (i_rx_byte),
        .i_frame_start  (i_frame_start),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_result_code  (o_result_code),
        .o_unit_id      (o_unit_id),
        .o_mode_status  (o_mode_status),
        .o_torque_raw   (o_torque_raw),
        .o_speed_raw    (o_speed_raw),
        .o_position_raw (o_position_raw),
        .o_temperature  (o_temperature),
        .o_motor_error  (o_motor_error),
        .o_load_raw     (o_load_raw)
    );

    mfr_checker u_frame_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .i_in_ready     (o_in_ready),
        .i_rx_byte      (i_rx_byte),
        .i_frame_start  (i_frame_start),
        .i_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .i_result_code  (o_result_code),
        .i_unit_id      (o_unit_id),
        .i_mode_status  (o_mode_status),
        .i_torque_raw   (o_torque_raw),
        .i_speed_raw    (o_speed_raw),
        .i_position_raw (o_position_raw),
        .i_temperature  (o_temperature),
        .i_motor_error  (o_motor_error),
        .i_load_raw     (o_load_raw),
        .o_mismatches   (mismatches),
        .o_pending      (pending),
        .o_results      (results),
        .o_codes_seen   (codes_seen)
    );

    // 12 ns clock
    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #2_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    // result side: its own ready pattern, plus one long hold on demand
    initial begin
        int unsigned rx_tick;
        t_rx_mode    rx_mode;
        rx_tick = 0;
        rx_mode = RX_OPEN;
        forever begin
            @(posedge i_clk);
            if (hold_wanted && !hold_served) begin
                i_out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                hold_served = 1'b1;
            end else begin
                rx_tick++;
                if (rx_tick % 160 == 0) begin
                    rx_mode = t_rx_mode'($urandom_range(0, 3));
                end
                case (rx_mode)
                    RX_OPEN: begin
                        i_out_ready <= 1'b1;
                    end
                    RX_MOSTLY: begin
                        i_out_ready <= ($urandom_range(0, 3) != 0);
                    end
                    RX_SPARSE: begin
                        i_out_ready <= ($urandom_range(0, 3) == 0);
                    end
                    default: begin
                        i_out_ready <= ((rx_tick % 7) < 3);
                    end
                endcase
            end
        end
    end

    // crc of bytes 0..13 into bytes 14 (high) and 15 (low)
    function automatic logic [127:0] seal_frame(input logic [127:0] f);
        logic [15:0] c;
        c = mfr_pkg::CRC_INIT;
        for (int k = 0; k < mfr_pkg::CRC_BYTES; k++) begin
            c = mfr_pkg::crc_byte(c, f[8*k +: 8]);
        end
        f[8*14 +: 8] = c[15:8];
        f[8*15 +: 8] = c[7:0];
        return f;
    endfunction

    // random frame, byte k at bits 8k+7..8k
    function automatic logic [127:0] build_frame(input t_frame_kind kind);
        logic [127:0] f;
        logic [7:0]   flip;
        int unsigned  pos;
        for (int k = 0; k < mfr_pkg::FRAME_BYTES; k++) begin
            f[8*k +: 8] = 8'($urandom_range(0, 255));
        end
        f[7:0]  = mfr_pkg::HEAD_0;
        f[15:8] = mfr_pkg::HEAD_1;
        f = seal_frame(f);
        case (kind)
            FK_BAD_HEAD: begin
                flip = 8'($urandom_range(1, 255));
                pos  = $urandom_range(0, 1);
                f[8*pos +: 8] = f[8*pos +: 8] ^ flip;
            end
            FK_BAD_CRC: begin
                // one bit flipped past the header always breaks the crc
                pos    = $urandom_range(16, 127);
                f[pos] = ~f[pos];
            end
            default: begin
            end
        endcase
        return f;
    endfunction

    // one byte request, with bursts and gaps ahead of it
    task automatic push_byte(input logic [7:0] b, input logic start);
        int unsigned gap;
        if (gaps_on && burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        if (burst_left != 0) begin
            burst_left--;
        end
        i_in_valid    <= 1'b1;
        i_rx_byte     <= b;
        i_frame_start <= start;
        do @(posedge i_clk); while (!o_in_ready);
        bytes_sent++;
    endtask

    // the first n bytes of a frame, start flag only on byte 0
    task automatic send_frame(input logic [127:0] f, input logic lead_start,
                              input int unsigned n_bytes);
        for (int k = 0; k < n_bytes; k++) begin
            push_byte(f[8*k +: 8], (k == 0) ? lead_start : 1'b0);
        end
    endtask

    // stop sending until every predicted result is out and the pipe is empty
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_motor_count(input logic [4:0] v);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        settings_written++;
    endtask

    // mostly well-formed frames, some noise, partial frames and trailing bytes
    task automatic random_frame();
        logic [127:0] f;
        int unsigned  r;
        int unsigned  n;
        r = $urandom_range(0, 99);
        if (r < 8) begin
            n = $urandom_range(1, 20);
            for (int i = 0; i < n; i++) begin
                push_byte(8'($urandom_range(0, 255)), ($urandom_range(0, 7) == 0));
            end
        end else if (r < 14) begin
            f = build_frame(FK_GOOD);
            send_frame(f, 1'b1, $urandom_range(1, mfr_pkg::FRAME_BYTES - 1));
        end
        r = $urandom_range(0, 99);
        if (r < 74) begin
            f = build_frame(FK_GOOD);
        end else if (r < 87) begin
            f = build_frame(FK_BAD_HEAD);
        end else begin
            f = build_frame(FK_BAD_CRC);
        end
        send_frame(f, 1'b1, mfr_pkg::FRAME_BYTES);
        if ($urandom_range(0, 4) == 0) begin
            n = $urandom_range(1, 3);
            for (int i = 0; i < n; i++) begin
                push_byte(8'($urandom_range(0, 255)), 1'b0);
            end
        end
    endtask

    task automatic random_phase(input logic [4:0] count, input int unsigned budget);
        int unsigned first;
        wait_idle();
        write_motor_count(count);
        first = bytes_sent;
        while (bytes_sent - first < budget) begin
            random_frame();
        end
    endtask

    // main sequence
    initial begin
        logic [127:0] f;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // first frame after reset without a start flag, all-ones payload, id 0
        f = build_frame(FK_GOOD);
        for (int k = 3; k < mfr_pkg::CRC_BYTES; k++) begin
            f[8*k +: 8] = 8'hFF;
        end
        f[23:16] = 8'hF0;
        f = seal_frame(f);
        send_frame(f, 1'b0, mfr_pkg::FRAME_BYTES);

        // bytes after a complete frame are dropped
        push_byte(8'hFD, 1'b0);
        push_byte(8'hEE, 1'b0);

        // partial frame cut short by a new start
        f = build_frame(FK_GOOD);
        send_frame(f, 1'b1, 5);

        // all-zero payload, id 1
        f = build_frame(FK_GOOD);
        for (int k = 3; k < mfr_pkg::CRC_BYTES; k++) begin
            f[8*k +: 8] = 8'h00;
        end
        f[23:16] = 8'h01;
        f = seal_frame(f);
        send_frame(f, 1'b1, mfr_pkg::FRAME_BYTES);

        // signed extremes with id 15, out of range at the reset motor count
        f = build_frame(FK_GOOD);
        f[23:16]   = 8'h8F;
        f[32 +: 64] = {32'h7FFF_FFFF, 16'h8000, 16'h7FFF};
        f = seal_frame(f);
        send_frame(f, 1'b1, mfr_pkg::FRAME_BYTES);

        // bad header carrying the most negative position
        f = build_frame(FK_BAD_HEAD);
        f[64 +: 32] = 32'h8000_0000;
        send_frame(f, 1'b1, mfr_pkg::FRAME_BYTES);

        // crc mismatch
        f = build_frame(FK_BAD_CRC);
        send_frame(f, 1'b1, mfr_pkg::FRAME_BYTES);

        random_phase(5'd1, 170);

        // a stretch with no sender gaps
        gaps_on = 1'b0;
        random_phase(5'd16, 170);
        gaps_on = 1'b1;

        // long result stall while frames keep coming, so the input backs up
        wait_idle();
        write_motor_count(5'd31);
        gaps_on     = 1'b0;
        hold_wanted = 1'b1;
        for (int i = 0; i < 4; i++) begin
            f = build_frame(FK_GOOD);
            send_frame(f, 1'b1, mfr_pkg::FRAME_BYTES);
        end
        while (!hold_served) @(posedge i_clk);
        hold_wanted = 1'b0;
        gaps_on     = 1'b1;

        random_phase(5'd31, 100);
        random_phase(5'd0, 170);
        random_phase(5'($urandom_range(3, 15)), 170);
        random_phase(5'd2, 170);

        // drain and let the block settle
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("run covered %0d byte requests and %0d frame results over %0d motor counts",
                 bytes_sent, results, settings_written);
        $display("result codes observed, one bit per code from ok up: %b", codes_seen);
        if (mismatches == 0 && pending == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/mfr_pkg.sv
rtl/core/mfr_frame_core.sv
rtl/core/motor_feedback_frame_receiver.sv
test/mfr_checker.sv
test/tb.sv
